// ===== hdl/life_automaton_board_unit_macros.svh =====
// Assertion macros shared by the life board RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LIFE_AUTOMATON_BOARD_UNIT_MACROS_SVH
`define LIFE_AUTOMATON_BOARD_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define LAB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life board assertion failed");

// Next-cycle implication
`define LAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life board assertion failed");

`else

`define LAB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LAB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/lab_pkg.sv =====
// Shared constants, request codes and controller/datapath structs for the life board.
// No dependencies.
`default_nettype none

package lab_pkg;

    localparam int unsigned DEF_ROWS    = 16;
    localparam int unsigned DEF_COLUMNS = 32;

    localparam int unsigned KIND_W = 2;
    localparam int unsigned POS_W  = 10;

    localparam logic [KIND_W-1:0] REQ_TOGGLE  = 2'd0;
    localparam logic [KIND_W-1:0] REQ_ADVANCE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_READ    = 2'd2;
    localparam logic [KIND_W-1:0] REQ_UNUSED  = 2'd3;

    // Fixed-point shift for the reciprocal that splits a position into row and column
    localparam int unsigned RECIP_SHIFT = 20;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic col_load;
        logic rd_en;
        logic rd_req_row;
        logic shift;
        logic save_first;
        logic wr_gen;
        logic wr_wrap;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic req_valid;
        logic req_advance;
        logic req_bad;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/lab_if.sv =====
// Request and response channel interfaces of the life board.
// Depends on lab_pkg.
`default_nettype none

interface lab_req_if;
    import lab_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [POS_W-1:0]  cell_position;

    modport source (output valid, output req_type, output cell_position, input ready);
    modport sink   (input valid, input req_type, input cell_position, output ready);
endinterface

interface lab_rsp_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic status;

    modport source (output valid, output cell_alive, output status, input ready);
    modport sink   (input valid, input cell_alive, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/lab_control.sv =====
// Controller of the life board: request sequencing and the row sweep of a generation.
// Depends on lab_pkg and the assertion macro header.
`default_nettype none
`include "life_automaton_board_unit_macros.svh"

module lab_control #(
    parameter int unsigned ROWS = lab_pkg::DEF_ROWS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire lab_pkg::t_stat           i_stat,
    output lab_pkg::t_cmd                 o_cmd,
    output logic [$clog2(ROWS)-1:0]       o_rd_row,
    output logic [$clog2(ROWS)-1:0]       o_wr_row
);
    import lab_pkg::*;

    localparam int unsigned ROW_W    = $clog2(ROWS);
    localparam int unsigned CNT_LAST = ROWS + 2;
    localparam int unsigned CNT_W    = $clog2(CNT_LAST + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOCATE = 2'd1;
    localparam logic [1:0] S_GEN    = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Sweep step k: read row k-1 (row ROWS-1 first), write new row k-3
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        o_rd_row = (r_cnt == '0) ? ROW_W'(ROWS - 1) : ROW_W'(r_cnt - CNT_W'(1));
        o_wr_row = ROW_W'(r_cnt - CNT_W'(3));
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    if (i_stat.req_bad) begin
                        n_state = S_RESULT;
                    end else if (i_stat.req_advance) begin
                        n_state = S_GEN;
                    end else begin
                        n_state = S_LOCATE;
                    end
                end
            end
            S_LOCATE: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_req_row = 1'b1;
                o_cmd.col_load   = 1'b1;
                n_state          = S_RESULT;
            end
            S_GEN: begin
                o_cmd.rd_en      = (r_cnt <= CNT_W'(ROWS));
                o_cmd.shift      = (r_cnt != '0);
                o_cmd.save_first = (r_cnt == CNT_W'(2));
                o_cmd.wr_gen     = (r_cnt >= CNT_W'(3));
                o_cmd.wr_wrap    = (r_cnt == CNT_W'(CNT_LAST));
                if (r_cnt == CNT_W'(CNT_LAST)) begin
                    n_state = S_RESULT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `LAB_ASSERT_NEXT(a_load_to_idle, i_clk, i_rst_n, o_cmd.out_load, r_state == S_IDLE)
    `LAB_ASSERT_NEXT(a_capture_busy, i_clk, i_rst_n, o_cmd.capture, r_state != S_IDLE)
    `LAB_ASSERT_IMPL(a_rows_apart, i_clk, i_rst_n, o_cmd.wr_gen && o_cmd.rd_en, o_rd_row != o_wr_row)
    `LAB_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, r_state == S_GEN, r_cnt <= CNT_W'(CNT_LAST))
    `LAB_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, o_cmd.out_load, i_stat.out_free)

endmodule

`default_nettype wire

// ===== hdl/lab_datapath.sv =====
// Datapath of the life board: row memory, row window, rule logic and result register.
// Depends on lab_pkg and lab_if.
`default_nettype none

module lab_datapath #(
    parameter int unsigned ROWS    = lab_pkg::DEF_ROWS,
    parameter int unsigned COLUMNS = lab_pkg::DEF_COLUMNS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    lab_req_if.sink                       i_req,
    lab_rsp_if.source                     o_rsp,
    input  wire lab_pkg::t_cmd            i_cmd,
    input  wire logic [$clog2(ROWS)-1:0]  i_rd_row,
    input  wire logic [$clog2(ROWS)-1:0]  i_wr_row,
    output lab_pkg::t_stat                o_stat
);
    import lab_pkg::*;

    localparam int unsigned ROW_W   = $clog2(ROWS);
    localparam int unsigned COL_W   = $clog2(COLUMNS);
    localparam int unsigned CELLS   = ROWS * COLUMNS;
    localparam int unsigned RECIP   = ((1 << RECIP_SHIFT) + COLUMNS - 1) / COLUMNS;
    localparam int unsigned PROD_W  = POS_W + RECIP_SHIFT;

    // Row store; rows never written since reset read as dead
    logic [COLUMNS-1:0] r_mem [ROWS];
    logic [ROWS-1:0]    r_row_valid;
    logic [COLUMNS-1:0] r_rd_data;
    logic               r_rd_ok;

    logic [KIND_W-1:0]  r_kind;
    logic [POS_W-1:0]   r_pos;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               r_bad;

    logic [COLUMNS-1:0] r_prev, r_cur, r_first;

    logic               r_out_valid;
    logic               r_out_alive;
    logic               r_out_status;

    logic               w_in_range;
    logic               w_bad;
    logic [PROD_W-1:0]  w_prod;
    logic [POS_W-1:0]   w_row_base;
    logic [COLUMNS-1:0] w_rd_eff;
    logic [COLUMNS-1:0] w_next;
    logic [COLUMNS-1:0] w_gen_row;
    logic [COLUMNS-1:0] w_col_mask;
    logic               w_cell;
    logic               w_wr_en;
    logic [ROW_W-1:0]   w_wr_addr;
    logic [ROW_W-1:0]   w_rd_addr;
    logic [COLUMNS-1:0] w_wr_data;
    logic               w_alive;

    // Request decode
    assign w_in_range = (32'(i_req.cell_position) < 32'(CELLS));
    assign w_bad      = (i_req.req_type == REQ_UNUSED) ||
                        ((i_req.req_type != REQ_ADVANCE) && !w_in_range);
    // row = position / COLUMNS by reciprocal, exact for positions below 2^RECIP_SHIFT/COLUMNS
    assign w_prod     = PROD_W'(i_req.cell_position) * PROD_W'(RECIP);
    assign w_row_base = POS_W'(POS_W'(r_row) * POS_W'(COLUMNS));

    assign i_req.ready        = i_cmd.in_ready;
    assign o_stat.req_valid   = i_req.valid;
    assign o_stat.req_advance = (i_req.req_type == REQ_ADVANCE);
    assign o_stat.req_bad     = w_bad;
    assign o_stat.out_free    = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_req.req_type;
            r_pos  <= i_req.cell_position;
            r_row  <= w_prod[RECIP_SHIFT +: ROW_W];
            r_bad  <= w_bad;
        end
        if (i_cmd.col_load) begin
            r_col <= COL_W'(r_pos - w_row_base);
        end
    end

    // Memory ports
    assign w_rd_addr  = i_cmd.rd_req_row ? r_row : i_rd_row;
    assign w_rd_eff   = r_rd_ok ? r_rd_data : '0;
    assign w_col_mask = {{(COLUMNS-1){1'b0}}, 1'b1} << r_col;
    assign w_cell     = w_rd_eff[r_col];
    assign w_wr_en    = i_cmd.wr_gen ||
                        (i_cmd.out_load && (r_kind == REQ_TOGGLE) && !r_bad);
    assign w_wr_addr  = i_cmd.wr_gen ? i_wr_row : r_row;
    assign w_wr_data  = i_cmd.wr_gen ? w_gen_row : (w_rd_eff ^ w_col_mask);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_ok   <= r_row_valid[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (w_wr_en) begin
            r_row_valid[w_wr_addr] <= 1'b1;
        end
    end

    // Three-row window of the old board
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_prev <= r_cur;
            r_cur  <= w_rd_eff;
        end
        if (i_cmd.save_first) begin
            r_first <= w_rd_eff;
        end
    end

    // Last row wraps onto the saved old row 0, already overwritten in memory
    assign w_next = i_cmd.wr_wrap ? r_first : w_rd_eff;

    always_comb begin
        logic [3:0]       nbr;
        logic [COL_W-1:0] cl;
        logic [COL_W-1:0] cr;
        w_gen_row = '0;
        for (int c = 0; c < COLUMNS; c++) begin
            cl  = (c == 0) ? COL_W'(COLUMNS - 1) : COL_W'(c - 1);
            cr  = (c == COLUMNS - 1) ? '0 : COL_W'(c + 1);
            nbr = 4'(r_prev[cl]) + 4'(r_prev[c]) + 4'(r_prev[cr]) +
                  4'(r_cur[cl])  + 4'(r_cur[cr]) +
                  4'(w_next[cl]) + 4'(w_next[c]) + 4'(w_next[cr]);
            w_gen_row[c] = (nbr == 4'd3) || (r_cur[c] && (nbr == 4'd2));
        end
    end

    // Result register
    always_comb begin
        case (r_kind)
            REQ_TOGGLE: w_alive = !r_bad && !w_cell;
            REQ_READ:   w_alive = !r_bad && w_cell;
            default:    w_alive = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_alive  <= w_alive;
            r_out_status <= r_bad;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cell_alive = r_out_alive;
    assign o_rsp.status     = r_out_status;

endmodule

`default_nettype wire

// ===== hdl/life_automaton_board_unit.sv =====
// Toroidal life board. Toggle and read locate the row, then load the result register; an
// off-board position or unused type skips the locate step. A generation sweeps the row
// store, one read port, one row per cycle, before the result register loads.
// One item in work at a time; the next is taken the cycle after the result register loads.
// Synchronous reset clears the per-row valid flags, so the board reads all dead at once.
`default_nettype none

module life_automaton_board_unit #(
    parameter int unsigned BOARD_ROWS    = lab_pkg::DEF_ROWS,
    parameter int unsigned BOARD_COLUMNS = lab_pkg::DEF_COLUMNS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lab_req_if.sink    i_req,
    lab_rsp_if.source  o_rsp
);
    import lab_pkg::*;

    t_cmd                          w_cmd;
    t_stat                         w_stat;
    logic [$clog2(BOARD_ROWS)-1:0] w_rd_row;
    logic [$clog2(BOARD_ROWS)-1:0] w_wr_row;

    lab_control #(
        .ROWS (BOARD_ROWS)
    ) u_control (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_rd_row (w_rd_row),
        .o_wr_row (w_wr_row)
    );

    lab_datapath #(
        .ROWS    (BOARD_ROWS),
        .COLUMNS (BOARD_COLUMNS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .i_cmd    (w_cmd),
        .i_rd_row (w_rd_row),
        .i_wr_row (w_wr_row),
        .o_stat   (w_stat)
    );

endmodule

`default_nettype wire
